>>> design/assert_macros.svh
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant check failed");

// same-cycle implication
`define ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

>>> design/vtdv_pkg.sv
// ----------------------------------------------------------------------------
// vtdv_pkg
// Shared types and constants of the temporal derivative variance block.
// ----------------------------------------------------------------------------
package vtdv_pkg;

  localparam int unsigned VOXELS_DEF        = 65536;
  localparam int unsigned MAX_FRAMES_DEF    = 4096;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SKIP_W    = 13;
  localparam int unsigned FNUM_W    = 13;
  localparam int unsigned VALUE_W   = 42;
  localparam int unsigned VSUM_W    = 46;
  localparam int unsigned VFC_W     = 13;
  localparam int unsigned FSUM_W    = 50;
  localparam int unsigned FCNT_W    = 17;
  localparam int unsigned SQ_W      = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SKIP_FRAMES    = 2'd0,
    CFG_MASK_ENABLE    = 2'd1,
    CFG_MASK_THRESHOLD = 2'd2,
    CFG_ROOT_OUTPUT    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    JOB_CONST = 2'd0,
    JOB_EMPTY = 2'd1,
    JOB_DIV   = 2'd2,
    JOB_RMS   = 2'd3
  } job_op_t;

  typedef struct packed {
    logic [SKIP_W-1:0]          skip_frames;
    logic                       mask_enable;
    logic signed [SAMPLE_W-1:0] mask_threshold;
    logic                       root_output;
  } cfg_t;

  typedef struct packed {
    job_op_t             op;
    logic                kind;
    logic [FNUM_W-1:0]   frame_number;
    logic [FCNT_W-1:0]   voxel_count;
    logic [FSUM_W-1:0]   num;
    logic [FCNT_W-1:0]   den;
  } job_t;

endpackage

>>> design/vtdv_front.sv
// ----------------------------------------------------------------------------
// vtdv_front
// Accepts samples and readouts, keeps the per-voxel store and frame sums,
// and issues constant, no-data, division and root jobs to the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtdv_front #(
  parameter int unsigned VOXELS     = vtdv_pkg::VOXELS_DEF,
  parameter int unsigned MAX_FRAMES = vtdv_pkg::MAX_FRAMES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vtdv_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vtdv_pkg::CFG_DAT_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  operation,
  input  logic [vtdv_pkg::INDEX_W-1:0]          voxel_index,
  input  logic signed [vtdv_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  sample_invalid,
  input  logic signed [vtdv_pkg::SAMPLE_W-1:0]  mask_value,
  input  logic                                  frame_end,
  output vtdv_pkg::job_t                        job,
  output logic                                  job_push,
  input  logic                                  job_full
);

  localparam int unsigned DEPTH  = (VOXELS > 65536) ? 65536 : VOXELS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FIDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned CMP_W  = (FIDX_W > vtdv_pkg::SKIP_W) ? FIDX_W : vtdv_pkg::SKIP_W;

  typedef struct packed {
    logic [vtdv_pkg::SAMPLE_W-1:0] prev;
    logic [vtdv_pkg::VSUM_W-1:0]   ssum;
    logic [vtdv_pkg::VFC_W-1:0]    cnt;
  } entry_t;

  typedef enum logic [3:0] {
    F_CLEAR  = 4'b0001,
    F_IDLE   = 4'b0010,
    F_SQUARE = 4'b0100,
    F_UPDATE = 4'b1000
  } fstate_t;

  fstate_t state, state_next;

  vtdv_pkg::cfg_t cfg;

  entry_t mem [DEPTH];
  entry_t rd;
  logic   mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t mem_wdata;
  logic [ADDR_W-1:0] clr_addr;

  logic in_accept;

  // item held while it is worked on
  logic                          op_q;
  logic                          in_range_q;
  logic [ADDR_W-1:0]             addr_q;
  logic signed [vtdv_pkg::SAMPLE_W-1:0] sample_q;
  logic                          invalid_q;
  logic signed [vtdv_pkg::SAMPLE_W-1:0] mask_q;
  logic                          fend_q;

  logic                          use_q;
  logic [vtdv_pkg::SQ_W-1:0]     sq_q;

  logic [vtdv_pkg::FSUM_W-1:0]   frame_sum, frame_sum_next;
  logic [vtdv_pkg::FCNT_W-1:0]   frame_cnt, frame_cnt_next;
  logic [FIDX_W-1:0]             frame_idx;

  logic                          use_now;
  logic signed [vtdv_pkg::SAMPLE_W:0] diff;
  logic [vtdv_pkg::SAMPLE_W:0]   abs_diff;
  logic [2*vtdv_pkg::SAMPLE_W+1:0] prod;
  logic                          need_push;
  logic                          go;
  logic                          vox_add;
  logic [FIDX_W:0]               fnum;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == F_IDLE);
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (vtdv_pkg::cfg_reg_t'(cfg_index))
        vtdv_pkg::CFG_SKIP_FRAMES:    cfg.skip_frames    <= cfg_data[vtdv_pkg::SKIP_W-1:0];
        vtdv_pkg::CFG_MASK_ENABLE:    cfg.mask_enable    <= cfg_data[0];
        vtdv_pkg::CFG_MASK_THRESHOLD: cfg.mask_threshold <= $signed(cfg_data);
        vtdv_pkg::CFG_ROOT_OUTPUT:    cfg.root_output    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-voxel store: one write port, registered read at accept
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (in_accept) rd <= mem[voxel_index[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q       <= operation;
      in_range_q <= ({1'b0, voxel_index} < 17'(DEPTH));
      addr_q     <= voxel_index[ADDR_W-1:0];
      sample_q   <= sample;
      invalid_q  <= sample_invalid;
      mask_q     <= mask_value;
      fend_q     <= frame_end;
    end
    if (state == F_SQUARE) begin
      use_q <= use_now;
      sq_q  <= prod[vtdv_pkg::SQ_W-1:0];
    end
  end

  always_comb begin
    use_now = !op_q && in_range_q && !invalid_q && (sample_q != '0);
    if (cfg.mask_enable && ($signed(mask_q) <= $signed(cfg.mask_threshold))) use_now = 1'b0;
    if ((rd.prev == '0) && (frame_idx != '0)) use_now = 1'b0;
    diff     = $signed({sample_q[vtdv_pkg::SAMPLE_W-1], sample_q})
             - $signed({rd.prev[vtdv_pkg::SAMPLE_W-1], rd.prev});
    abs_diff = diff[vtdv_pkg::SAMPLE_W] ? 17'(-diff) : 17'(diff);
    prod     = abs_diff * abs_diff;
  end

  always_comb begin
    frame_sum_next = frame_sum;
    frame_cnt_next = frame_cnt;
    if (use_q && (frame_cnt != {vtdv_pkg::FCNT_W{1'b1}})) begin
      frame_sum_next = frame_sum + vtdv_pkg::FSUM_W'(sq_q);
      frame_cnt_next = frame_cnt + 1'b1;
    end
    vox_add = use_q && (CMP_W'(frame_idx) > CMP_W'(cfg.skip_frames))
            && (rd.cnt != {vtdv_pkg::VFC_W{1'b1}});
    fnum = {1'b0, frame_idx} + 1'b1;

    job = '0;
    if (op_q) begin
      job.kind = 1'b1;
      job.num  = vtdv_pkg::FSUM_W'(rd.ssum);
      job.den  = vtdv_pkg::FCNT_W'(rd.cnt);
      if (in_range_q && (rd.cnt != '0)) begin
        job.op = cfg.root_output ? vtdv_pkg::JOB_RMS : vtdv_pkg::JOB_DIV;
      end else begin
        job.op = vtdv_pkg::JOB_EMPTY;
      end
    end else begin
      job.kind         = 1'b0;
      job.frame_number = vtdv_pkg::FNUM_W'(fnum);
      job.voxel_count  = frame_cnt_next;
      job.num          = frame_sum_next;
      job.den          = frame_cnt_next;
      if (frame_idx == '0)          job.op = vtdv_pkg::JOB_CONST;
      else if (frame_cnt_next == '0) job.op = vtdv_pkg::JOB_EMPTY;
      else                           job.op = vtdv_pkg::JOB_RMS;
    end

    need_push = op_q || fend_q;
    go        = (state == F_UPDATE) && (!need_push || !job_full);
    job_push  = go && need_push;

    mem_we    = (state == F_CLEAR) || (go && use_q);
    mem_waddr = (state == F_CLEAR) ? clr_addr : addr_q;
    mem_wdata = '0;
    if (state != F_CLEAR) begin
      mem_wdata.prev = sample_q;
      mem_wdata.ssum = vox_add ? rd.ssum + vtdv_pkg::VSUM_W'(sq_q) : rd.ssum;
      mem_wdata.cnt  = vox_add ? rd.cnt + 1'b1 : rd.cnt;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_CLEAR:  if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = F_IDLE;
      F_IDLE:   if (in_accept) state_next = F_SQUARE;
      F_SQUARE: state_next = F_UPDATE;
      F_UPDATE: if (go) state_next = F_IDLE;
      default:  state_next = F_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_CLEAR;
      clr_addr  <= '0;
      frame_sum <= '0;
      frame_cnt <= '0;
      frame_idx <= '0;
    end else begin
      state <= state_next;
      if (state == F_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (go && !op_q) begin
        if (fend_q) begin
          frame_sum <= '0;
          frame_cnt <= '0;
          if (frame_idx != FIDX_W'(MAX_FRAMES - 1)) frame_idx <= frame_idx + 1'b1;
        end else begin
          frame_sum <= frame_sum_next;
          frame_cnt <= frame_cnt_next;
        end
      end
    end
  end

  `ASSERT_IMPL(a_push_has_room, job_push, !job_full)
  `ASSERT_NEXT(a_frame_close_clears, go && !op_q && fend_q,
               (frame_cnt == '0) && (frame_sum == '0))

endmodule

>>> design/vtdv_queue.sv
// ----------------------------------------------------------------------------
// vtdv_queue
// Short job queue between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtdv_queue (
  input  logic           clk,
  input  logic           rst,
  input  vtdv_pkg::job_t din,
  input  logic           push,
  output logic           full,
  output vtdv_pkg::job_t dout,
  input  logic           pop,
  output logic           empty
);

  localparam int unsigned PTR_W = $clog2(vtdv_pkg::QUEUE_DEPTH);

  vtdv_pkg::job_t    slots [vtdv_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (PTR_W+1)'(vtdv_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= (PTR_W+1)'(vtdv_pkg::QUEUE_DEPTH))

endmodule

>>> design/vtdv_back.sv
// ----------------------------------------------------------------------------
// vtdv_back
// Runs queued jobs: bit-serial scaled division, bit-pair square root,
// saturation, and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtdv_back #(
  parameter int unsigned FRACTION_BITS = vtdv_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  vtdv_pkg::job_t                      job,
  input  logic                                job_empty,
  output logic                                job_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                result_kind,
  output logic [vtdv_pkg::FNUM_W-1:0]         frame_number,
  output logic [vtdv_pkg::VALUE_W-1:0]        value,
  output logic                                no_data,
  output logic [vtdv_pkg::FCNT_W-1:0]         voxel_count
);

  localparam int unsigned NW    = vtdv_pkg::FSUM_W + 2 * FRACTION_BITS;
  localparam int unsigned RW    = NW / 2;
  localparam int unsigned STEP_W = $clog2(NW + 1);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_SQRT = 4'b0100,
    B_DONE = 4'b1000
  } bstate_t;

  bstate_t state;

  vtdv_pkg::job_t               cur;
  logic [NW-1:0]                dvd;
  logic [vtdv_pkg::FCNT_W-1:0]  rem;
  logic [STEP_W-1:0]            step;
  logic [RW:0]                  srem;
  logic [RW-1:0]                root;
  logic [vtdv_pkg::VALUE_W-1:0] res;
  logic                         res_nd;

  logic [vtdv_pkg::FCNT_W:0]    r2;
  logic                         q_bit;
  logic [RW+2:0]                s2;
  logic [RW+2:0]                trial;
  logic                         r_bit;
  logic                         out_free;

  assign job_pop  = (state == B_IDLE) && !job_empty;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    r2    = {rem, dvd[NW-1]};
    q_bit = (r2 >= {1'b0, cur.den});
    s2    = {srem, dvd[NW-1:NW-2]};
    trial = (RW+3)'({root, 2'b01});
    r_bit = (s2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in the done state the output register is loaded below instead
      if (out_valid && out_ready && (state != B_DONE)) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!job_empty) begin
            cur  <= job;
            rem  <= '0;
            step <= '0;
            if (job.op == vtdv_pkg::JOB_RMS)
              dvd <= NW'(job.num) << (2 * FRACTION_BITS);
            else
              dvd <= NW'(job.num) << FRACTION_BITS;
            unique case (job.op)
              vtdv_pkg::JOB_CONST: begin
                res    <= vtdv_pkg::VALUE_W'(500) << FRACTION_BITS;
                res_nd <= 1'b0;
                state  <= B_DONE;
              end
              vtdv_pkg::JOB_EMPTY: begin
                res    <= '0;
                res_nd <= 1'b1;
                state  <= B_DONE;
              end
              default: begin
                res_nd <= 1'b0;
                state  <= B_DIV;
              end
            endcase
          end
        end
        B_DIV: begin
          // restoring division, one quotient bit a cycle, quotient shifts into dvd
          rem  <= q_bit ? vtdv_pkg::FCNT_W'(r2 - {1'b0, cur.den})
                        : r2[vtdv_pkg::FCNT_W-1:0];
          dvd  <= {dvd[NW-2:0], q_bit};
          step <= step + 1'b1;
          if (step == STEP_W'(NW - 1)) begin
            step <= '0;
            srem <= '0;
            root <= '0;
            if (cur.op == vtdv_pkg::JOB_RMS) begin
              state <= B_SQRT;
            end else begin
              if ({dvd[NW-2:0], q_bit} > NW'({vtdv_pkg::VALUE_W{1'b1}}))
                res <= {vtdv_pkg::VALUE_W{1'b1}};
              else
                res <= vtdv_pkg::VALUE_W'({dvd[NW-2:0], q_bit});
              state <= B_DONE;
            end
          end
        end
        B_SQRT: begin
          // two radicand bits a cycle
          srem <= r_bit ? (RW+1)'(s2 - trial) : (RW+1)'(s2);
          root <= {root[RW-2:0], r_bit};
          dvd  <= {dvd[NW-3:0], 2'b00};
          step <= step + 1'b1;
          if (step == STEP_W'(RW - 1)) begin
            res   <= vtdv_pkg::VALUE_W'({root[RW-2:0], r_bit});
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            result_kind  <= cur.kind;
            frame_number <= cur.frame_number;
            value        <= res;
            no_data      <= res_nd;
            voxel_count  <= cur.voxel_count;
            state        <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_div_nonzero_den, state == B_DIV, cur.den != '0)

endmodule

>>> design/voxel_temporal_derivative_variance.sv
// ----------------------------------------------------------------------------
// voxel_temporal_derivative_variance
// Frame-wise temporal derivative RMS and per-voxel derivative variance.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries voxel samples (operation 0) and
// voxel readouts (operation 1). A sample transfer with frame_end closes the
// frame and yields one frame RMS result; a readout yields one voxel result;
// other samples yield nothing. Results leave on out_valid/out_ready.
// Configuration writes go over cfg_valid/cfg_ready with cfg_index/cfg_data,
// always accepted; write them only while the block is idle.
// The front works on one item at a time: a registered read of the voxel
// store, the squared difference, and a write-back, then it takes the next.
// Results are computed behind a 4-entry job queue by a shared bit-serial
// divider and, for RMS or deviation, a root unit; first-frame and no-data
// results skip both, and results keep their order.
// After reset the voxel store is cleared one entry a cycle, all min(VOXELS,
// 65536) entries, with in_ready low; configuration is accepted meanwhile.
// When the receiver stalls, the output register holds, the queue fills and
// the front then holds its item and drops in_ready.
// ----------------------------------------------------------------------------
module voxel_temporal_derivative_variance #(
  parameter int unsigned VOXELS        = vtdv_pkg::VOXELS_DEF,
  parameter int unsigned MAX_FRAMES    = vtdv_pkg::MAX_FRAMES_DEF,
  parameter int unsigned FRACTION_BITS = vtdv_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vtdv_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vtdv_pkg::CFG_DAT_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  operation,
  input  logic [vtdv_pkg::INDEX_W-1:0]          voxel_index,
  input  logic signed [vtdv_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  sample_invalid,
  input  logic signed [vtdv_pkg::SAMPLE_W-1:0]  mask_value,
  input  logic                                  frame_end,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  result_kind,
  output logic [vtdv_pkg::FNUM_W-1:0]           frame_number,
  output logic [vtdv_pkg::VALUE_W-1:0]          value,
  output logic                                  no_data,
  output logic [vtdv_pkg::FCNT_W-1:0]           voxel_count
);

  vtdv_pkg::job_t job_in;
  vtdv_pkg::job_t job_out;
  logic           job_push;
  logic           job_full;
  logic           job_pop;
  logic           job_empty;

  vtdv_front #(
    .VOXELS     (VOXELS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .voxel_index    (voxel_index),
    .sample         (sample),
    .sample_invalid (sample_invalid),
    .mask_value     (mask_value),
    .frame_end      (frame_end),
    .job            (job_in),
    .job_push       (job_push),
    .job_full       (job_full)
  );

  vtdv_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .din   (job_in),
    .push  (job_push),
    .full  (job_full),
    .dout  (job_out),
    .pop   (job_pop),
    .empty (job_empty)
  );

  vtdv_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (job_out),
    .job_empty    (job_empty),
    .job_pop      (job_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .frame_number (frame_number),
    .value        (value),
    .no_data      (no_data),
    .voxel_count  (voxel_count)
  );

endmodule

>>> test/voxel_temporal_derivative_variance_test.sv
// ----------------------------------------------------------------------------
// voxel_temporal_derivative_variance_test
// Streams voxel frames and readouts through the block under random idling
// on both channels and checks every frame rms and voxel readout against a
// predictor of the derivative sums, under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_temporal_derivative_variance_test;

  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_READOUT  = 1'b1;
  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_VOXEL  = 1'b1;
  localparam int   FRAC        = 8;
  localparam int   LAST_FRAME  = 4095;
  localparam logic [63:0] VALUE_CAP = (64'd1 << 42) - 1;
  localparam int   VCNT_CAP    = 8191;
  localparam int   FCNT_CAP    = 131071;
  localparam int   STALL_LIMIT = 300000;
  localparam int   DRAIN_WAIT  = 200;

  typedef struct {
    logic                        kind;
    logic [vtdv_pkg::FNUM_W-1:0] fnum;
    logic [63:0]                 val;
    logic                        nd;
    logic [vtdv_pkg::FCNT_W-1:0] cnt;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vtdv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vtdv_pkg::CFG_DAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = OP_SAMPLE;
  logic [vtdv_pkg::INDEX_W-1:0] voxel_index = '0;
  logic signed [vtdv_pkg::SAMPLE_W-1:0] sample = '0;
  logic sample_invalid = 1'b0;
  logic signed [vtdv_pkg::SAMPLE_W-1:0] mask_value = '0;
  logic frame_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic result_kind;
  logic [vtdv_pkg::FNUM_W-1:0] frame_number;
  logic [vtdv_pkg::VALUE_W-1:0] value;
  logic no_data;
  logic [vtdv_pkg::FCNT_W-1:0] voxel_count;

  // predictor state
  logic [15:0] prev_smp [65536];
  logic [63:0] vox_sum [65536];
  int          vox_cnt [65536];
  logic [63:0] frm_sum;
  int          frm_cnt;
  int          frm_idx;
  int          skip_frames_r;
  logic        mask_en_r;
  int          mask_thr_r;
  logic        root_r;

  result_t pending_results[$];
  int fail_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit send_idle_en = 1'b1;
  bit recv_stall_en = 1'b1;
  int stall_left = 0;

  voxel_temporal_derivative_variance i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .voxel_index(voxel_index), .sample(sample),
    .sample_invalid(sample_invalid), .mask_value(mask_value),
    .frame_end(frame_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .frame_number(frame_number), .value(value),
    .no_data(no_data), .voxel_count(voxel_count)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] scaled_quot(logic [63:0] num, int den, int sh);
    logic [127:0] n;
    n = {64'd0, num} << sh;
    return 64'(n / den);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] clip(logic [63:0] v);
    return v > VALUE_CAP ? VALUE_CAP : v;
  endfunction

  // expected outcome of one accepted item
  function automatic void predict_derivative(logic op, logic [15:0] idx,
      logic signed [15:0] smp, logic inv, logic signed [15:0] msk, logic fe);
    result_t e;
    int d;
    logic [63:0] ad, sq;
    bit used;
    if (op == OP_READOUT) begin
      e.kind = KIND_VOXEL; e.fnum = '0; e.cnt = '0; e.val = 0; e.nd = 1'b1;
      if (vox_cnt[idx] != 0) begin
        e.nd = 1'b0;
        if (root_r) e.val = clip(int_sqrt(scaled_quot(vox_sum[idx], vox_cnt[idx], 2 * FRAC)));
        else e.val = clip(scaled_quot(vox_sum[idx], vox_cnt[idx], FRAC));
      end
      pending_results.push_back(e);
      return;
    end
    used = 1'b1;
    if (mask_en_r && int'(msk) <= mask_thr_r) used = 1'b0;
    if (inv || smp == 0) used = 1'b0;
    if (prev_smp[idx] == 0 && frm_idx != 0) used = 1'b0;
    if (used) begin
      d = int'(smp) - int'($signed(prev_smp[idx]));
      ad = d < 0 ? -d : d;
      sq = ad * ad;
      prev_smp[idx] = smp;
      if (frm_cnt < FCNT_CAP) begin
        frm_cnt++;
        frm_sum += sq;
      end
      if (frm_idx > skip_frames_r && vox_cnt[idx] < VCNT_CAP) begin
        vox_cnt[idx]++;
        vox_sum[idx] += sq;
      end
    end
    if (!fe) return;
    e.kind = KIND_FRAME;
    e.fnum = vtdv_pkg::FNUM_W'(frm_idx + 1);
    e.cnt = vtdv_pkg::FCNT_W'(frm_cnt);
    if (frm_idx == 0) begin
      e.val = clip(64'd500 << FRAC); e.nd = 1'b0;
    end else if (frm_cnt == 0) begin
      e.val = 0; e.nd = 1'b1;
    end else begin
      e.val = clip(int_sqrt(scaled_quot(frm_sum, frm_cnt, 2 * FRAC))); e.nd = 1'b0;
    end
    pending_results.push_back(e);
    frm_sum = 0;
    frm_cnt = 0;
    if (frm_idx < LAST_FRAME) frm_idx++;
  endfunction

  task automatic send_item(logic op, logic [15:0] idx, logic signed [15:0] smp,
      logic inv, logic signed [15:0] msk, logic fe);
    int g;
    g = send_idle_en ? gap_len() : 0;
    @(negedge clk);
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    operation = op; voxel_index = idx; sample = smp;
    sample_invalid = inv; mask_value = msk; frame_end = fe;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_derivative(op, idx, smp, inv, msk, fe);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(vtdv_pkg::cfg_reg_t r, logic [15:0] d);
    stop_sending();
    wait (pending_results.size() == 0);
    repeat (150) @(posedge clk);
    @(negedge clk);
    cfg_index = r; cfg_data = d; cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (r)
      vtdv_pkg::CFG_SKIP_FRAMES:    skip_frames_r = d[12:0];
      vtdv_pkg::CFG_MASK_ENABLE:    mask_en_r = d[0];
      vtdv_pkg::CFG_MASK_THRESHOLD: mask_thr_r = int'($signed(d));
      vtdv_pkg::CFG_ROOT_OUTPUT:    root_r = d[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int skip, bit men, int thr, bit root);
    write_reg(vtdv_pkg::CFG_SKIP_FRAMES, 16'(skip));
    write_reg(vtdv_pkg::CFG_MASK_ENABLE, 16'(men));
    write_reg(vtdv_pkg::CFG_MASK_THRESHOLD, 16'(thr));
    write_reg(vtdv_pkg::CFG_ROOT_OUTPUT, 16'(root));
  endtask

  function automatic logic [15:0] pick_voxel();
    int r;
    r = $urandom_range(0, 29);
    if (r == 0) return 16'hFFFF;
    if (r < 3) return 16'($urandom());
    return 16'($urandom_range(0, 15));
  endfunction

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return 16'd0;
    if (r < 4) return 16'($urandom());
    if (r == 4) return r[0] ? 16'h7FFF : 16'h8000;
    return 16'($signed($urandom_range(0, 400)) - 200 + 1000);
  endfunction

  function automatic logic [15:0] pick_mask();
    if ($urandom_range(0, 1)) return 16'($urandom());
    return 16'(mask_thr_r + $signed($urandom_range(0, 4)) - 2);
  endfunction

  // well-formed frames with readouts between them, plus a little noise
  task automatic random_frames(int n_items);
    int stop_at, len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++)
        send_item($urandom_range(0, 24) == 0 ? OP_READOUT : OP_SAMPLE, pick_voxel(),
                  pick_sample(), $urandom_range(0, 15) == 0, pick_mask(), k == len - 1);
      repeat ($urandom_range(0, 3))
        send_item(OP_READOUT, pick_voxel(), 16'($urandom()), 1'($urandom()),
                  16'($urandom()), 1'($urandom()));
    end
  endtask

  task automatic test_directed();
    // first frame: absent previous samples count as zero
    send_item(OP_READOUT, 16'd3, 16'sd0, 1'b0, 16'sd0, 1'b1);
    send_item(OP_SAMPLE, 16'd0, 16'h7FFF, 1'b0, 16'sd0, 1'b0);
    send_item(OP_SAMPLE, 16'd1, 16'h8000, 1'b0, 16'sd0, 1'b0);
    send_item(OP_SAMPLE, 16'd2, 16'sd0, 1'b0, 16'sd0, 1'b0);
    send_item(OP_SAMPLE, 16'd3, 16'sd55, 1'b1, 16'sd0, 1'b0);
    send_item(OP_SAMPLE, 16'hFFFF, 16'sd9, 1'b0, 16'h7FFF, 1'b1);
    // second frame: largest difference, voxel never written is skipped
    send_item(OP_SAMPLE, 16'd1, 16'h7FFF, 1'b0, 16'h8000, 1'b0);
    send_item(OP_SAMPLE, 16'd0, 16'h8000, 1'b0, 16'sd0, 1'b0);
    send_item(OP_SAMPLE, 16'd4, 16'sd100, 1'b0, 16'sd0, 1'b1);
    // empty frame
    send_item(OP_SAMPLE, 16'd5, 16'sd7, 1'b0, 16'sd0, 1'b1);
    send_item(OP_SAMPLE, 16'd0, 16'sd0, 1'b0, 16'sd0, 1'b1);
    send_item(OP_SAMPLE, 16'd0, 16'sd1, 1'b0, 16'sd0, 1'b0);
    send_item(OP_SAMPLE, 16'd1, 16'sd1, 1'b0, 16'sd0, 1'b1);
    send_item(OP_READOUT, 16'd0, 16'sd0, 1'b0, 16'sd0, 1'b0);
    send_item(OP_READOUT, 16'd1, 16'sd0, 1'b0, 16'sd0, 1'b1);
    send_item(OP_READOUT, 16'hFFFF, 16'sd0, 1'b0, 16'sd0, 1'b0);
    send_item(OP_READOUT, 16'd9, 16'sd0, 1'b0, 16'sd0, 1'b0);
  endtask

  task automatic test_default_setting();
    random_frames(180);
  endtask

  task automatic test_root_and_mask();
    set_config(2, 1'b1, -32768, 1'b1);
    random_frames(150);
    set_config(1, 1'b1, $signed($urandom_range(0, 2000)) - 1000, 1'b0);
    random_frames(150);
  endtask

  task automatic test_no_voxel_accumulation();
    set_config(4096, 1'b1, 32767, 1'b1);
    random_frames(40);
    set_config(4096, 1'b0, 16'($urandom()), 1'b0);
    random_frames(80);
  endtask

  task automatic test_back_to_back();
    set_config(0, 1'b0, 0, 1'b1);
    send_idle_en = 1'b0;
    recv_stall_en = 1'b0;
    random_frames(120);
    send_idle_en = 1'b1;
    recv_stall_en = 1'b1;
    random_frames(120);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", value, 0);
      end else begin
        e = pending_results.pop_front();
        if (result_kind !== e.kind) report_mismatch("result_kind", result_kind, e.kind);
        if (frame_number !== e.fnum) report_mismatch("frame_number", frame_number, e.fnum);
        if (value !== e.val[vtdv_pkg::VALUE_W-1:0]) report_mismatch("value", value, e.val);
        if (no_data !== e.nd) report_mismatch("no_data", no_data, e.nd);
        if (voxel_count !== e.cnt) report_mismatch("voxel_count", voxel_count, e.cnt);
      end
    end
  end

  always @(negedge clk) begin
    if (!recv_stall_en) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= gap_len();
      out_ready <= 1'b1;
    end
  end

  // watchdog on transfers of any kind
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("voxel_temporal_derivative_variance_test NOT OK");
      $finish;
    end
  end

  initial begin
    foreach (prev_smp[i]) begin
      prev_smp[i] = 0; vox_sum[i] = 0; vox_cnt[i] = 0;
    end
    frm_sum = 0; frm_cnt = 0; frm_idx = 0;
    skip_frames_r = 0; mask_en_r = 1'b0; mask_thr_r = 0; root_r = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_default_setting();
    test_root_and_mask();
    test_no_voxel_accumulation();
    test_back_to_back();
    stop_sending();
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("voxel_temporal_derivative_variance_test OK");
    else
      $display("voxel_temporal_derivative_variance_test NOT OK");
    $finish;
  end

endmodule
